>>> sv/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared codes, constants and the backoff delay table for the link
// reconnect backoff state machine and its checker.
// ----------------------------------------------------------------------------
package lrb_pkg;

    // Event codes
    localparam logic [2:0] CMD_POLL          = 3'd0;
    localparam logic [2:0] CMD_LINK_ALIVE    = 3'd1;
    localparam logic [2:0] CMD_LINK_LOST     = 3'd2;
    localparam logic [2:0] CMD_SYNC_RESPONSE = 3'd3;
    localparam logic [2:0] CMD_START         = 3'd4;
    localparam logic [2:0] CMD_STOP          = 3'd5;

    // Link states
    localparam logic [1:0] ST_CONNECTED    = 2'd0;
    localparam logic [1:0] ST_DISCONNECTED = 2'd1;
    localparam logic [1:0] ST_RECONNECTING = 2'd2;
    localparam logic [1:0] ST_SYNCING      = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_STARTED = 2'd1;
    localparam logic [1:0] STATUS_SHORT_FRAME = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_HB_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_LOCAL_SEQ    = 2'd3;

    // Configuration reset values
    localparam logic [15:0] ACK_TIMEOUT_RESET  = 16'd500;
    localparam logic [15:0] HB_INTERVAL_RESET  = 16'd1000;
    localparam logic [15:0] SYNC_TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] LOCAL_SEQ_RESET    = 16'd0;

    // Minimum sync response length in bytes
    localparam logic [15:0] MIN_SYNC_LENGTH = 16'd2;

    // Half of the 32-bit time range, for wrap-safe deadline tests
    localparam logic [31:0] TIME_HALF = 32'h8000_0000;

    // Number of backoff steps in use; the index stops at the last one
    localparam int BACKOFF_STEPS = 8;
    localparam int BACKOFF_USED  = (BACKOFF_STEPS < 1) ? 1 :
                                   ((BACKOFF_STEPS > 8) ? 8 : BACKOFF_STEPS);
    localparam logic [2:0] BACKOFF_CAP = 3'(BACKOFF_USED - 1);

    // Backoff delay in milliseconds for a table index
    function automatic logic [31:0] backoff_delay(input logic [2:0] idx);
        logic [31:0] d;
        case (idx)
            3'd0:    d = 32'd100;
            3'd1:    d = 32'd200;
            3'd2:    d = 32'd400;
            3'd3:    d = 32'd800;
            3'd4:    d = 32'd1600;
            3'd5:    d = 32'd5000;
            3'd6:    d = 32'd10000;
            default: d = 32'd30000;
        endcase
        return d;
    endfunction

endpackage

>>> sv/link_reconnect_backoff_fsm.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm
// Four-state link manager with exponential reconnect backoff, heartbeat
// requests, sync timeout and downtime statistics. One result per event.
// ----------------------------------------------------------------------------
// Path: an accepted event is held in the input register, then the state
//   update is written together with the result register.
// Throughput: one event per cycle unless out_stall holds the result; the state
//   update is one pass of short compare and add logic between the two registers.
// Reset: rst_n clears the link state, counters and pipeline valids at once
//   and loads the configuration registers with their defaults.
module link_reconnect_backoff_fsm
(
    input  logic        clk,
    input  logic        rst_n,

    // Event input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [31:0] now_ms,
    input  logic        tx_ok,
    input  logic [15:0] frame_length,
    input  logic [15:0] peer_sequence,

    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  conn_state,
    output logic [1:0]  status,
    output logic        hb_request,
    output logic        send_sync,
    output logic [2:0]  retry_step,
    output logic [31:0] attempt_total,
    output logic [31:0] connect_total,
    output logic [31:0] downtime_total_ms,
    output logic [15:0] remote_sequence,

    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    logic [15:0] ack_timeout_reg;
    logic [15:0] hb_interval_reg;
    logic [15:0] sync_timeout_reg;
    logic [15:0] local_seq_reg;

    // Input stage
    logic        s1_valid_reg;
    logic [2:0]  s1_cmd_reg;
    logic [31:0] s1_now_reg;
    logic        s1_tx_ok_reg;
    logic [15:0] s1_flen_reg;
    logic [15:0] s1_pseq_reg;

    // Link state
    logic [1:0]  state_reg,           state_next;
    logic        started_reg,         started_next;
    logic [31:0] last_ack_reg,        last_ack_next;
    logic [31:0] last_hb_reg,         last_hb_next;
    logic [2:0]  backoff_idx_reg,     backoff_idx_next;
    logic [31:0] next_attempt_reg,    next_attempt_next;
    logic [31:0] down_since_reg,      down_since_next;
    logic        down_valid_reg,      down_valid_next;
    logic [31:0] attempt_cnt_reg,     attempt_cnt_next;
    logic [31:0] success_cnt_reg,     success_cnt_next;
    logic [31:0] downtime_reg,        downtime_next;
    logic [15:0] peer_seq_reg,        peer_seq_next;
    logic        sync_waiting_reg,    sync_waiting_next;
    logic [31:0] sync_begin_reg,      sync_begin_next;
    logic        sync_begin_vld_reg,  sync_begin_vld_next;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic        out_hb_reg;
    logic        out_sync_reg;

    logic [1:0]  status_c;
    logic        hb_c;
    logic        sync_c;

    logic        in_xfer;
    logic        out_free;
    logic        s1_adv;

    // Handshake: the input register moves on whenever the result slot frees
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg  <= lrb_pkg::ACK_TIMEOUT_RESET;
            hb_interval_reg  <= lrb_pkg::HB_INTERVAL_RESET;
            sync_timeout_reg <= lrb_pkg::SYNC_TIMEOUT_RESET;
            local_seq_reg    <= lrb_pkg::LOCAL_SEQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrb_pkg::REG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_data;
                lrb_pkg::REG_HB_INTERVAL:  hb_interval_reg  <= cfg_data;
                lrb_pkg::REG_SYNC_TIMEOUT: sync_timeout_reg <= cfg_data;
                lrb_pkg::REG_LOCAL_SEQ:    local_seq_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Capture an event on input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg   <= cmd;
            s1_now_reg   <= now_ms;
            s1_tx_ok_reg <= tx_ok;
            s1_flen_reg  <= frame_length;
            s1_pseq_reg  <= peer_sequence;
        end
    end

    // Event processing: next link state and result flags
    always_comb
    begin
        logic [31:0] sb_time;
        logic [31:0] ack_age;
        logic [31:0] hb_age;
        logic [31:0] due_age;
        logic [31:0] sync_age;

        state_next          = state_reg;
        started_next        = started_reg;
        last_ack_next       = last_ack_reg;
        last_hb_next        = last_hb_reg;
        backoff_idx_next    = backoff_idx_reg;
        next_attempt_next   = next_attempt_reg;
        down_since_next     = down_since_reg;
        down_valid_next     = down_valid_reg;
        attempt_cnt_next    = attempt_cnt_reg;
        success_cnt_next    = success_cnt_reg;
        downtime_next       = downtime_reg;
        peer_seq_next       = peer_seq_reg;
        sync_waiting_next   = sync_waiting_reg;
        sync_begin_next     = sync_begin_reg;
        sync_begin_vld_next = sync_begin_vld_reg;
        status_c            = lrb_pkg::STATUS_OK;
        hb_c                = 1'b0;
        sync_c              = 1'b0;

        sb_time  = sync_begin_vld_reg ? sync_begin_reg : s1_now_reg;
        ack_age  = s1_now_reg - last_ack_reg;
        hb_age   = s1_now_reg - last_hb_reg;
        due_age  = s1_now_reg - next_attempt_reg;
        sync_age = s1_now_reg - sb_time;

        case (s1_cmd_reg)
            lrb_pkg::CMD_POLL:
            begin
                if (!started_reg)
                begin
                    status_c = lrb_pkg::STATUS_NOT_STARTED;
                end
                else
                begin
                    case (state_reg)
                        lrb_pkg::ST_CONNECTED:
                        begin
                            // Drop the link on ACK timeout
                            if (ack_age >= {16'd0, ack_timeout_reg})
                            begin
                                state_next        = lrb_pkg::ST_DISCONNECTED;
                                down_since_next   = s1_now_reg;
                                down_valid_next   = 1'b1;
                                backoff_idx_next  = 3'd0;
                                next_attempt_next = s1_now_reg + lrb_pkg::backoff_delay(3'd0);
                                attempt_cnt_next  = 32'd0;
                            end
                            // Request a heartbeat when the interval has passed
                            if (hb_age >= {16'd0, hb_interval_reg})
                            begin
                                hb_c         = 1'b1;
                                last_hb_next = s1_now_reg;
                            end
                        end
                        lrb_pkg::ST_DISCONNECTED:
                        begin
                            // Start an attempt once the deadline is due
                            if (due_age < lrb_pkg::TIME_HALF)
                            begin
                                state_next        = lrb_pkg::ST_RECONNECTING;
                                attempt_cnt_next  = attempt_cnt_reg + 32'd1;
                                next_attempt_next = s1_now_reg +
                                                    lrb_pkg::backoff_delay(backoff_idx_reg);
                                if (backoff_idx_reg < lrb_pkg::BACKOFF_CAP)
                                begin
                                    backoff_idx_next = backoff_idx_reg + 3'd1;
                                end
                            end
                        end
                        lrb_pkg::ST_RECONNECTING:
                        begin
                            sync_c = 1'b1;
                            if (s1_tx_ok_reg)
                            begin
                                state_next        = lrb_pkg::ST_SYNCING;
                                sync_waiting_next = 1'b1;
                            end
                            else
                            begin
                                next_attempt_next = s1_now_reg +
                                                    lrb_pkg::backoff_delay(backoff_idx_reg);
                                if (backoff_idx_reg < lrb_pkg::BACKOFF_CAP)
                                begin
                                    backoff_idx_next = backoff_idx_reg + 3'd1;
                                end
                            end
                        end
                        default:
                        begin
                            // Syncing: mark the start of the wait on the first poll
                            sync_begin_next     = sb_time;
                            sync_begin_vld_next = 1'b1;
                            // Restart the attempt on sync timeout
                            if (sync_age > {16'd0, sync_timeout_reg})
                            begin
                                sync_begin_vld_next = 1'b0;
                                state_next          = lrb_pkg::ST_RECONNECTING;
                                attempt_cnt_next    = attempt_cnt_reg + 32'd1;
                                next_attempt_next   = s1_now_reg +
                                                      lrb_pkg::backoff_delay(backoff_idx_reg);
                                if (backoff_idx_reg < lrb_pkg::BACKOFF_CAP)
                                begin
                                    backoff_idx_next = backoff_idx_reg + 3'd1;
                                end
                            end
                            // Complete the connect once the response has arrived
                            if (!sync_waiting_reg)
                            begin
                                state_next       = lrb_pkg::ST_CONNECTED;
                                last_ack_next    = s1_now_reg;
                                last_hb_next     = s1_now_reg;
                                backoff_idx_next = 3'd0;
                                success_cnt_next = success_cnt_reg + 32'd1;
                                if (down_valid_reg)
                                begin
                                    downtime_next   = downtime_reg +
                                                      (s1_now_reg - down_since_reg);
                                    down_valid_next = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            lrb_pkg::CMD_LINK_ALIVE:
            begin
                last_ack_next = s1_now_reg;
                if (state_reg != lrb_pkg::ST_CONNECTED)
                begin
                    state_next       = lrb_pkg::ST_CONNECTED;
                    last_hb_next     = s1_now_reg;
                    backoff_idx_next = 3'd0;
                    success_cnt_next = success_cnt_reg + 32'd1;
                    if (down_valid_reg)
                    begin
                        downtime_next   = downtime_reg + (s1_now_reg - down_since_reg);
                        down_valid_next = 1'b0;
                    end
                end
            end
            lrb_pkg::CMD_LINK_LOST:
            begin
                if (state_reg != lrb_pkg::ST_DISCONNECTED)
                begin
                    state_next        = lrb_pkg::ST_DISCONNECTED;
                    down_since_next   = s1_now_reg;
                    down_valid_next   = 1'b1;
                    backoff_idx_next  = 3'd0;
                    next_attempt_next = s1_now_reg + lrb_pkg::backoff_delay(3'd0);
                    attempt_cnt_next  = 32'd0;
                end
            end
            lrb_pkg::CMD_SYNC_RESPONSE:
            begin
                if (s1_flen_reg < lrb_pkg::MIN_SYNC_LENGTH)
                begin
                    status_c = lrb_pkg::STATUS_SHORT_FRAME;
                end
                else
                begin
                    peer_seq_next     = s1_pseq_reg;
                    sync_waiting_next = 1'b0;
                end
            end
            lrb_pkg::CMD_START:
            begin
                state_next          = lrb_pkg::ST_CONNECTED;
                started_next        = 1'b1;
                last_ack_next       = s1_now_reg;
                last_hb_next        = s1_now_reg;
                backoff_idx_next    = 3'd0;
                next_attempt_next   = 32'd0;
                down_since_next     = 32'd0;
                down_valid_next     = 1'b0;
                attempt_cnt_next    = 32'd0;
                success_cnt_next    = 32'd0;
                downtime_next       = 32'd0;
                peer_seq_next       = 16'd0;
                sync_waiting_next   = 1'b0;
                sync_begin_next     = 32'd0;
                sync_begin_vld_next = 1'b0;
            end
            lrb_pkg::CMD_STOP:
            begin
                started_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // Forget the sync start whenever syncing is left
        if (state_next != lrb_pkg::ST_SYNCING)
        begin
            sync_begin_vld_next = 1'b0;
        end
    end

    // Update link state as an event moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= lrb_pkg::ST_CONNECTED;
            started_reg        <= 1'b0;
            last_ack_reg       <= 32'd0;
            last_hb_reg        <= 32'd0;
            backoff_idx_reg    <= 3'd0;
            next_attempt_reg   <= 32'd0;
            down_since_reg     <= 32'd0;
            down_valid_reg     <= 1'b0;
            attempt_cnt_reg    <= 32'd0;
            success_cnt_reg    <= 32'd0;
            downtime_reg       <= 32'd0;
            peer_seq_reg       <= 16'd0;
            sync_waiting_reg   <= 1'b0;
            sync_begin_reg     <= 32'd0;
            sync_begin_vld_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            state_reg          <= state_next;
            started_reg        <= started_next;
            last_ack_reg       <= last_ack_next;
            last_hb_reg        <= last_hb_next;
            backoff_idx_reg    <= backoff_idx_next;
            next_attempt_reg   <= next_attempt_next;
            down_since_reg     <= down_since_next;
            down_valid_reg     <= down_valid_next;
            attempt_cnt_reg    <= attempt_cnt_next;
            success_cnt_reg    <= success_cnt_next;
            downtime_reg       <= downtime_next;
            peer_seq_reg       <= peer_seq_next;
            sync_waiting_reg   <= sync_waiting_next;
            sync_begin_reg     <= sync_begin_next;
            sync_begin_vld_reg <= sync_begin_vld_next;
        end
    end

    // Result register: hold while stalled, drop after output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_status_reg <= status_c;
            out_hb_reg     <= hb_c;
            out_sync_reg   <= sync_c;
        end
    end

    // Counters and state are shown from the state registers after each event
    assign out_valid         = out_valid_reg;
    assign conn_state        = state_reg;
    assign status            = out_status_reg;
    assign hb_request        = out_hb_reg;
    assign send_sync         = out_sync_reg;
    assign retry_step        = backoff_idx_reg;
    assign attempt_total     = attempt_cnt_reg;
    assign connect_total     = success_cnt_reg;
    assign downtime_total_ms = downtime_reg;
    assign remote_sequence   = peer_seq_reg;

endmodule

>>> sv/lrb_checker.sv
// ----------------------------------------------------------------------------
// lrb_checker
// Port-level checks for the link reconnect backoff state machine, bound to
// the top level.
// ----------------------------------------------------------------------------
module lrb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  conn_state,
    input logic [1:0]  status,
    input logic        hb_request,
    input logic        send_sync
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A refused or rejected event requests no transmission
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != lrb_pkg::STATUS_OK) |-> !hb_request && !send_sync)
        else $error("transmit request on an error status");

    // A sync request comes only from reconnecting, which leads to reconnecting or syncing
    a_sync_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_sync |->
            (conn_state == lrb_pkg::ST_RECONNECTING) || (conn_state == lrb_pkg::ST_SYNCING))
        else $error("sync request in wrong link state");

    // A heartbeat request comes only from a connected poll
    a_hb_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hb_request |->
            ((conn_state == lrb_pkg::ST_CONNECTED) ||
             (conn_state == lrb_pkg::ST_DISCONNECTED)) && !send_sync)
        else $error("heartbeat request in wrong link state");

endmodule

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .conn_state (conn_state),
    .status     (status),
    .hb_request (hb_request),
    .send_sync  (send_sync)
);
